// ----- rtl/core/cuckoo_pkg.sv -----
// Shared types and constants for the cuckoo hash insert block.
`default_nettype none
package cuckoo_pkg;
	localparam int KEY_W = 64;
	localparam int PAY_W = 16;
	localparam int KICK_W = 7;
	localparam int SLOT_W = 13;
	localparam int MAX_INDEX_BITS = 16;

	localparam int INDEX_BITS_DEF = 13;
	localparam int SECOND_HASH_SHIFT_DEF = 16;
	localparam int MAX_KICKS_DEF = 64;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] pay;
	} entry_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS,
		ST_RESULT
	} state_t;
endpackage
`default_nettype wire

// ----- rtl/core/cuckoo_table.sv -----
// Slot memory with one write port, one registered read port and write-to-read forwarding.
`default_nettype none
module cuckoo_table #(
	parameter int INDEX_BITS = cuckoo_pkg::INDEX_BITS_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      rd_en,
	input  wire [INDEX_BITS-1:0]     rd_addr,
	input  wire                      wr_en,
	input  wire [INDEX_BITS-1:0]     wr_addr,
	input  wire cuckoo_pkg::entry_t  wr_data,
	output cuckoo_pkg::entry_t       rd_data
);
	import cuckoo_pkg::*;

	localparam int DEPTH = 1 << INDEX_BITS;

	entry_t mem [DEPTH];
	entry_t rd_raw_q;
	entry_t fwd_data_q;
	logic   fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem[rd_addr];
		end
		fwd_data_q <= wr_data;
	end

	// A read of the entry being written this cycle must see the new contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (rd_addr == wr_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_raw_q;
endmodule
`default_nettype wire

// ----- rtl/core/cuckoo_hash_insert_top.sv -----
// Cuckoo hash table top level: request sequencer, kick loop and result register.
//
// After reset the block sweeps the table to empty, one slot per cycle, over all
// 2**INDEX_BITS slots (8192 by default); in_ready stays low until the sweep ends.
// A read request passes through ST_ACCESS and ST_RESULT before the next acceptance.
// An insert with k displacements makes its table accesses in ST_ACCESS and then passes
// ST_RESULT; each table access is one read-modify-write of the single table memory, in
// which the read of the next slot overlaps the write-back of the current one. k is at
// most MAX_KICKS; when that limit is reached the last displaced word is returned with
// dropped set.
// The finished result sits in an output register, so a new word can be accepted
// while the previous result waits for out_ready.
`default_nettype none
module cuckoo_hash_insert_top #(
	parameter int INDEX_BITS = cuckoo_pkg::INDEX_BITS_DEF,
	parameter int SECOND_HASH_SHIFT = cuckoo_pkg::SECOND_HASH_SHIFT_DEF,
	parameter int MAX_KICKS = cuckoo_pkg::MAX_KICKS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire                              req_type,
	input  wire [cuckoo_pkg::KEY_W-1:0]      key,
	input  wire [cuckoo_pkg::PAY_W-1:0]      payload,
	input  wire [cuckoo_pkg::SLOT_W-1:0]     slot_index,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [cuckoo_pkg::KICK_W-1:0]    kicks,
	output logic                             dropped,
	output logic [cuckoo_pkg::KEY_W-1:0]     out_key,
	output logic [cuckoo_pkg::PAY_W-1:0]     out_payload
);
	import cuckoo_pkg::*;

	localparam logic [INDEX_BITS-1:0] LAST_SLOT = {INDEX_BITS{1'b1}};
	localparam logic [KICK_W-1:0] KICK_LIMIT = KICK_W'(MAX_KICKS);

	state_t state_q, state_d;

	logic [INDEX_BITS-1:0] clr_cnt_q;
	logic [INDEX_BITS-1:0] slot_q;
	logic [KICK_W-1:0]     kick_cnt_q;
	logic                  is_read_q;
	entry_t                cur_q;

	logic [KICK_W-1:0]     res_kicks_q;
	logic                  res_dropped_q;
	entry_t                res_q;

	logic                  out_valid_q;
	logic [KICK_W-1:0]     out_kicks_q;
	logic                  out_dropped_q;
	entry_t                out_q;

	logic                  rd_en, wr_en;
	logic [INDEX_BITS-1:0] rd_addr, wr_addr;
	entry_t                wr_data, rd_data;

	logic                  accept, step, finish, out_load;
	logic [KICK_W-1:0]     kick_next;
	logic [KICK_W-1:0]     res_kicks_d;
	logic                  res_dropped_d;
	entry_t                res_d;

	logic [MAX_INDEX_BITS-1:0] slot_ext;
	logic [INDEX_BITS-1:0]     h1_in, read_slot, h1_old, h2_old, next_slot;

	assign slot_ext  = {{(MAX_INDEX_BITS-SLOT_W){1'b0}}, slot_index};
	assign read_slot = slot_ext[INDEX_BITS-1:0];
	assign h1_in     = key[INDEX_BITS-1:0];
	assign h1_old    = rd_data.key[INDEX_BITS-1:0];
	assign h2_old    = rd_data.key[SECOND_HASH_SHIFT +: INDEX_BITS];
	// The displaced word moves to whichever of its two slots it was not found in.
	assign next_slot = (slot_q == h1_old) ? h2_old : h1_old;
	assign kick_next = kick_cnt_q + KICK_W'(1);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_load = !out_valid_q || out_ready;

	cuckoo_table #(
		.INDEX_BITS(INDEX_BITS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d       = state_q;
		rd_en         = 1'b0;
		rd_addr       = slot_q;
		wr_en         = 1'b0;
		wr_addr       = slot_q;
		wr_data       = cur_q;
		step          = 1'b0;
		finish        = 1'b0;
		res_kicks_d   = kick_cnt_q;
		res_dropped_d = 1'b0;
		res_d         = '0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_cnt_q;
				wr_data = '0;
				if (clr_cnt_q == LAST_SLOT) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					rd_en   = 1'b1;
					rd_addr = (req_type == REQ_READ) ? read_slot : h1_in;
					state_d = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				if (is_read_q) begin
					finish      = 1'b1;
					res_kicks_d = '0;
					res_d       = rd_data;
				end else begin
					wr_en = 1'b1;
					if (rd_data.pay == '0) begin
						finish = 1'b1;
					end else if (kick_next == KICK_LIMIT) begin
						finish        = 1'b1;
						res_kicks_d   = kick_next;
						res_dropped_d = 1'b1;
						res_d         = rd_data;
					end else begin
						step    = 1'b1;
						rd_en   = 1'b1;
						rd_addr = next_slot;
					end
				end
				if (finish) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + INDEX_BITS'(1);
			end
			if (state_q == ST_RESULT && out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_read_q  <= (req_type == REQ_READ);
			slot_q     <= h1_in;
			kick_cnt_q <= '0;
			cur_q.key  <= key;
			cur_q.pay  <= payload;
		end else if (step) begin
			slot_q     <= next_slot;
			kick_cnt_q <= kick_next;
			cur_q      <= rd_data;
		end
		if (finish) begin
			res_kicks_q   <= res_kicks_d;
			res_dropped_q <= res_dropped_d;
			res_q         <= res_d;
		end
		if (state_q == ST_RESULT && out_load) begin
			out_kicks_q   <= res_kicks_q;
			out_dropped_q <= res_dropped_q;
			out_q         <= res_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign kicks       = out_kicks_q;
	assign dropped     = out_dropped_q;
	assign out_key     = out_q.key;
	assign out_payload = out_q.pay;

	// A dropped word is only reported once the kick limit has been reached.
	a_drop_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && dropped) |-> (kicks == KICK_LIMIT))
		else $error("dropped result without reaching the kick limit");

	a_kick_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACCESS) |-> (kick_cnt_q < KICK_LIMIT))
		else $error("kick counter passed the limit");

	a_write_owner: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ((state_q == ST_CLEAR) || (state_q == ST_ACCESS && !is_read_q)))
		else $error("table written outside the clear sweep or an insert");

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_ACCESS && $past(rd_en)))
		else $error("accepted word did not start a table access");
endmodule
`default_nettype wire

// ----- tb/cuckoo_hash_insert_checker.sv -----
// Checker for the cuckoo hash block: shadow table, expected-result queue and compare.
module cuckoo_hash_insert_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  wire                          in_ready,
	input  wire                          req_type,
	input  wire [cuckoo_pkg::KEY_W-1:0]  key,
	input  wire [cuckoo_pkg::PAY_W-1:0]  payload,
	input  wire [cuckoo_pkg::SLOT_W-1:0] slot_index,
	input  wire                          out_valid,
	input  wire                          out_ready,
	input  wire [cuckoo_pkg::KICK_W-1:0] kicks,
	input  wire                          dropped,
	input  wire [cuckoo_pkg::KEY_W-1:0]  out_key,
	input  wire [cuckoo_pkg::PAY_W-1:0]  out_payload,
	output int                           errors,
	output int                           pending
);
	import cuckoo_pkg::*;

	localparam int SLOTS = 1 << INDEX_BITS_DEF;
	localparam int KICK_LIMIT = MAX_KICKS_DEF;

	typedef struct packed {
		logic [KICK_W-1:0] kicks;
		logic              dropped;
		logic [KEY_W-1:0]  key;
		logic [PAY_W-1:0]  pay;
	} outcome_t;

	logic [KEY_W-1:0] key_tbl [SLOTS];
	logic [PAY_W-1:0] pay_tbl [SLOTS];
	outcome_t outcome_q [$];

	function automatic logic [SLOT_W-1:0] first_slot(input logic [KEY_W-1:0] k);
		return k[SLOT_W-1:0];
	endfunction

	function automatic logic [SLOT_W-1:0] second_slot(input logic [KEY_W-1:0] k);
		return k[SECOND_HASH_SHIFT_DEF +: SLOT_W];
	endfunction

	// Runs the displacement chain on the shadow table and returns what the block should report.
	function automatic outcome_t place_pair(input logic [KEY_W-1:0] k, input logic [PAY_W-1:0] p);
		outcome_t res;
		logic [SLOT_W-1:0] slot;
		logic [KEY_W-1:0] held_key;
		logic [PAY_W-1:0] held_pay;
		int n;
		res = '0;
		slot = first_slot(k);
		n = 0;
		while (n < KICK_LIMIT) begin
			held_key = key_tbl[slot];
			held_pay = pay_tbl[slot];
			key_tbl[slot] = k;
			pay_tbl[slot] = p;
			k = held_key;
			p = held_pay;
			if (p == '0)
				break;
			// A pair found in its first slot moves to its second one, and the other way round.
			slot = (slot == first_slot(k)) ? second_slot(k) : first_slot(k);
			n++;
		end
		res.kicks = n[KICK_W-1:0];
		if (n >= KICK_LIMIT) begin
			res.dropped = 1'b1;
			res.key = k;
			res.pay = p;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
			input logic [KEY_W-1:0] want);
		errors++;
		$display("mismatch at %0t: %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				key_tbl[i] = '0;
				pay_tbl[i] = '0;
			end
			outcome_q.delete();
			errors = 0;
		end else begin
			// The result leaving now belongs to an earlier word, so compare before predicting.
			if (out_valid && out_ready) begin
				if (outcome_q.size() == 0) begin
					report_mismatch("result word with nothing expected", out_key, '0);
				end else begin
					want = outcome_q.pop_front();
					if (kicks !== want.kicks)
						report_mismatch("kicks", KEY_W'(kicks), KEY_W'(want.kicks));
					if (dropped !== want.dropped)
						report_mismatch("dropped", KEY_W'(dropped), KEY_W'(want.dropped));
					if (out_key !== want.key)
						report_mismatch("out_key", out_key, want.key);
					if (out_payload !== want.pay)
						report_mismatch("out_payload", KEY_W'(out_payload), KEY_W'(want.pay));
				end
			end
			if (in_valid && in_ready) begin
				if (req_type == REQ_READ) begin
					want = '0;
					want.key = key_tbl[slot_index];
					want.pay = pay_tbl[slot_index];
				end else begin
					want = place_pair(key, payload);
				end
				outcome_q.insert(outcome_q.size(), want);
			end
		end
		pending = outcome_q.size();
	end
endmodule

// ----- tb/cuckoo_hash_insert_top_tb.sv -----
// Testbench top for the cuckoo hash block: stimulus, handshake pacing and verdict.
module cuckoo_hash_insert_top_tb;
	import cuckoo_pkg::*;

	localparam int WATCHDOG_LIMIT = 50000;
	localparam int RANDOM_WORDS = 1430;
	localparam int ZONE_PERIOD = 180;
	localparam int TAIL_CYCLES = 100;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              req_type = REQ_INSERT;
	logic [KEY_W-1:0]  key = '0;
	logic [PAY_W-1:0]  payload = '0;
	logic [SLOT_W-1:0] slot_index = '0;
	logic              out_ready = 1'b0;
	wire               in_ready;
	wire               out_valid;
	wire [KICK_W-1:0]  kicks;
	wire               dropped;
	wire [KEY_W-1:0]   out_key;
	wire [PAY_W-1:0]   out_payload;

	int errors;
	int pending;
	int idle_cycles = 0;
	bit calm = 1'b0;
	logic [SLOT_W-1:0] zone_base = '0;
	int zone_span = 16;

	cuckoo_hash_insert_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.key(key),
		.payload(payload),
		.slot_index(slot_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kicks(kicks),
		.dropped(dropped),
		.out_key(out_key),
		.out_payload(out_payload)
	);

	cuckoo_hash_insert_checker table_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.key(key),
		.payload(payload),
		.slot_index(slot_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kicks(kicks),
		.dropped(dropped),
		.out_key(out_key),
		.out_payload(out_payload),
		.errors(errors),
		.pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 18);
	end

	// The reset sweep and the longest stall both fit well inside the limit.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_word(input logic rt, input logic [KEY_W-1:0] k,
			input logic [PAY_W-1:0] p, input logic [SLOT_W-1:0] s);
		while (!calm && $urandom_range(0, 99) < 18) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		key <= k;
		payload <= p;
		slot_index <= s;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	function automatic logic [KEY_W-1:0] key_for(input logic [SLOT_W-1:0] h1,
			input logic [SLOT_W-1:0] h2);
		logic [KEY_W-1:0] k;
		k = {$urandom, $urandom};
		k[SLOT_W-1:0] = h1;
		k[SECOND_HASH_SHIFT_DEF +: SLOT_W] = h2;
		return k;
	endfunction

	function automatic logic [SLOT_W-1:0] zone_slot();
		return SLOT_W'(zone_base + $urandom_range(0, zone_span - 1));
	endfunction

	function automatic logic [PAY_W-1:0] any_payload();
		return PAY_W'($urandom_range(1, 65535));
	endfunction

	initial begin
		logic [KEY_W-1:0] dup_key;
		int roll;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_word(REQ_READ, '0, '0, '0);
		send_word(REQ_READ, '1, '1, '1);
		// All-ones key hashes to the same slot twice; a second copy bounces until dropped.
		send_word(REQ_INSERT, '1, 16'hFFFF, '0);
		send_word(REQ_INSERT, '1, 16'h0001, '1);
		send_word(REQ_INSERT, '0, 16'h8000, '0);
		send_word(REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555, 13'h0AAA);
		send_word(REQ_INSERT, 64'h5555_5555_5555_5555, 16'h2AAA, 13'h1555);
		// A pair stored with a zero payload counts as empty when it is taken out again.
		send_word(REQ_INSERT, key_for(13'd100, 13'd200), '0, '0);
		send_word(REQ_INSERT, key_for(13'd100, 13'd201), 16'h0042, '0);
		send_word(REQ_READ, '0, '0, 13'd100);
		dup_key = key_for(13'd300, 13'd301);
		send_word(REQ_INSERT, dup_key, 16'h0101, '0);
		send_word(REQ_INSERT, key_for(13'd300, 13'd302), 16'h0202, '0);
		send_word(REQ_INSERT, key_for(13'd301, 13'd303), 16'h0303, '0);
		send_word(REQ_READ, '0, '0, 13'd300);
		send_word(REQ_READ, '0, '0, 13'd301);
		send_word(REQ_READ, '0, '0, 13'd302);
		send_word(REQ_INSERT, dup_key, 16'h0404, '0);
		send_word(REQ_READ, '0, '0, 13'd8191);
		send_word(REQ_READ, '0, '0, 13'd0);
		wait_for_results();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// Most inserts aim at a narrow band of slots so that chains grow long and overflow.
			if (n % ZONE_PERIOD == 0) begin
				case ($urandom_range(0, 3))
					0: zone_span = 4;
					1: zone_span = 16;
					2: zone_span = 64;
					default: zone_span = 512;
				endcase
				zone_base = SLOT_W'($urandom);
			end
			calm = (n >= 500 && n < 700);
			if (n == 900)
				wait_for_results();
			roll = $urandom_range(0, 99);
			if (roll < 9)
				send_word(REQ_READ, {$urandom, $urandom}, PAY_W'($urandom), zone_slot());
			else if (roll < 15)
				send_word(REQ_READ, {$urandom, $urandom}, PAY_W'($urandom), SLOT_W'($urandom));
			else if (roll < 75)
				send_word(REQ_INSERT, key_for(zone_slot(), zone_slot()), any_payload(),
					SLOT_W'($urandom));
			else
				send_word(REQ_INSERT, {$urandom, $urandom}, any_payload(), SLOT_W'($urandom));
		end
		calm = 1'b0;
		wait_for_results();
		repeat (TAIL_CYCLES) @(negedge clk);

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ----- cuckoo_hash_insert_top.f -----
rtl/core/cuckoo_pkg.sv
rtl/core/cuckoo_table.sv
rtl/core/cuckoo_hash_insert_top.sv
tb/cuckoo_hash_insert_checker.sv
tb/cuckoo_hash_insert_top_tb.sv
